/* sv/wsdf_pkg.sv */
// Shared types and constants for the WebSocket frame deframer.
package wsdf_pkg;

  // Parse phase, one-hot
  typedef enum logic [4:0] {
    PH_HDR0   = 5'b00001,
    PH_HDR1   = 5'b00010,
    PH_EXTLEN = 5'b00100,
    PH_KEY    = 5'b01000,
    PH_BODY   = 5'b10000
  } phase_t;

  // Event kinds on the result channel
  localparam logic [2:0] EV_PAYLOAD = 3'd0;
  localparam logic [2:0] EV_MSG_END = 3'd1;
  localparam logic [2:0] EV_PING    = 3'd2;
  localparam logic [2:0] EV_PONG    = 3'd3;
  localparam logic [2:0] EV_UNKNOWN = 3'd4;

  // Frame opcodes
  localparam logic [3:0] OP_CONT   = 4'h0;
  localparam logic [3:0] OP_TEXT   = 4'h1;
  localparam logic [3:0] OP_BINARY = 4'h2;
  localparam logic [3:0] OP_PING   = 4'h9;
  localparam logic [3:0] OP_PONG   = 4'hA;

  // 7-bit length codes that announce an extended length
  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;
  localparam logic [3:0] KEY_BYTES   = 4'd4;

endpackage

/* sv/websocket_frame_deframer.sv */
// Receive-side WebSocket frame deframer: header parse, unmask, event generation.
// A byte is held in the input register, then its result in the result register on out_*.
// Throughput: one byte per cycle while out_tready is high. in_tready follows out_tready
// via the input register: one more byte is taken while a result waits, then input stalls.
// Reset (rst_n low, synchronous): parser returns to the first header byte, all
// parse state is cleared and both channels are emptied.
module websocket_frame_deframer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] payload_byte, [11:8] message_opcode, [15:12] zero
  output logic [2:0]  out_tuser,  // [2:0] event_kind
  output logic        out_tlast   // last_of_message
);

  // Input register
  logic       in_vld_r, in_vld_nxt;
  logic [7:0] in_byte_r;

  // Parse state
  wsdf_pkg::phase_t phase_r, phase_nxt;
  logic        fin_r, fin_nxt;
  logic [3:0]  fop_r, fop_nxt;
  logic        mask_r, mask_nxt;
  logic [3:0]  hbc_r, hbc_nxt;
  logic [63:0] rem_r, rem_nxt;
  logic [31:0] key_r, key_nxt;
  logic [1:0]  mpos_r, mpos_nxt;
  logic [3:0]  fragop_r, fragop_nxt;
  logic        ext8_r, ext8_nxt;

  // Result register
  logic       out_vld_r, out_vld_nxt;
  logic [2:0] out_kind_r;
  logic [7:0] out_byte_r;
  logic [3:0] out_op_r;
  logic       out_last_r;

  logic       proc;
  logic       emit;
  logic [2:0] emit_kind;
  logic [7:0] emit_byte;
  logic [3:0] emit_op;
  logic       emit_last;

  logic       is_data;
  logic [3:0] msg_op;
  logic       fe_emit;
  logic [2:0] fe_kind;
  logic       fe_last;
  logic [3:0] hbc_inc;
  logic [6:0] len7;
  logic       rem_one;
  logic [7:0] key_byte;

  assign proc      = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !in_vld_r || proc;

  assign is_data = (fop_r == wsdf_pkg::OP_CONT) || (fop_r == wsdf_pkg::OP_TEXT) ||
                   (fop_r == wsdf_pkg::OP_BINARY);
  assign msg_op  = (fop_r == wsdf_pkg::OP_CONT) ? fragop_r : fop_r;
  assign hbc_inc = hbc_r + 4'd1;
  assign len7    = in_byte_r[6:0];
  assign rem_one = (rem_r == 64'd1);

  always_comb begin
    case (mpos_r)
      2'd0:    key_byte = key_r[31:24];
      2'd1:    key_byte = key_r[23:16];
      2'd2:    key_byte = key_r[15:8];
      default: key_byte = key_r[7:0];
    endcase
  end

  // Event for a frame that ends with no payload shown
  always_comb begin
    fe_emit = 1'b1;
    fe_last = 1'b0;
    fe_kind = wsdf_pkg::EV_UNKNOWN;
    if (is_data) begin
      fe_emit = fin_r;
      fe_last = 1'b1;
      fe_kind = wsdf_pkg::EV_MSG_END;
    end else if (fop_r == wsdf_pkg::OP_PING) begin
      fe_kind = wsdf_pkg::EV_PING;
    end else if (fop_r == wsdf_pkg::OP_PONG) begin
      fe_kind = wsdf_pkg::EV_PONG;
    end
  end

  always_comb begin
    phase_nxt  = phase_r;
    fin_nxt    = fin_r;
    fop_nxt    = fop_r;
    mask_nxt   = mask_r;
    hbc_nxt    = hbc_r;
    rem_nxt    = rem_r;
    key_nxt    = key_r;
    mpos_nxt   = mpos_r;
    fragop_nxt = fragop_r;
    ext8_nxt   = ext8_r;
    emit       = 1'b0;
    emit_kind  = fe_kind;
    emit_byte  = 8'd0;
    emit_op    = is_data ? msg_op : fop_r;
    emit_last  = fe_last;

    if (proc) begin
      unique case (phase_r)
        wsdf_pkg::PH_HDR1: begin
          mask_nxt = in_byte_r[7];
          hbc_nxt  = 4'd0;
          if (len7 == wsdf_pkg::LEN_EXT16 || len7 == wsdf_pkg::LEN_EXT64) begin
            rem_nxt   = 64'd0;
            ext8_nxt  = (len7 == wsdf_pkg::LEN_EXT64);
            phase_nxt = wsdf_pkg::PH_EXTLEN;
          end else begin
            rem_nxt = {57'd0, len7};
            if (in_byte_r[7]) begin
              phase_nxt = wsdf_pkg::PH_KEY;
              key_nxt   = 32'd0;
            end else begin
              mpos_nxt = 2'd0;
              if (len7 == 7'd0) begin
                phase_nxt = wsdf_pkg::PH_HDR0;
                emit      = fe_emit;
              end else begin
                phase_nxt = wsdf_pkg::PH_BODY;
              end
            end
          end
        end
        wsdf_pkg::PH_EXTLEN: begin
          rem_nxt = {rem_r[55:0], in_byte_r};
          hbc_nxt = hbc_inc;
          if (hbc_inc >= (ext8_r ? wsdf_pkg::EXT64_BYTES : wsdf_pkg::EXT16_BYTES)) begin
            hbc_nxt = 4'd0;
            if (mask_r) begin
              phase_nxt = wsdf_pkg::PH_KEY;
              key_nxt   = 32'd0;
            end else begin
              mpos_nxt = 2'd0;
              if ({rem_r[55:0], in_byte_r} == 64'd0) begin
                phase_nxt = wsdf_pkg::PH_HDR0;
                emit      = fe_emit;
              end else begin
                phase_nxt = wsdf_pkg::PH_BODY;
              end
            end
          end
        end
        wsdf_pkg::PH_KEY: begin
          key_nxt = {key_r[23:0], in_byte_r};
          hbc_nxt = hbc_inc;
          if (hbc_inc >= wsdf_pkg::KEY_BYTES) begin
            hbc_nxt  = 4'd0;
            mpos_nxt = 2'd0;
            if (rem_r == 64'd0) begin
              phase_nxt = wsdf_pkg::PH_HDR0;
              emit      = fe_emit;
            end else begin
              phase_nxt = wsdf_pkg::PH_BODY;
            end
          end
        end
        wsdf_pkg::PH_BODY: begin
          mpos_nxt = mpos_r + 2'd1;
          rem_nxt  = rem_r - 64'd1;
          if (rem_one) phase_nxt = wsdf_pkg::PH_HDR0;
          if (is_data) begin
            emit      = 1'b1;
            emit_kind = wsdf_pkg::EV_PAYLOAD;
            emit_byte = mask_r ? (in_byte_r ^ key_byte) : in_byte_r;
            emit_last = fin_r && rem_one;
          end else begin
            emit = rem_one;
          end
        end
        default: begin
          // First header byte; an impossible phase lands here too
          fin_nxt = in_byte_r[7];
          fop_nxt = in_byte_r[3:0];
          if (!in_byte_r[7] && (in_byte_r[3:0] == wsdf_pkg::OP_TEXT ||
                                in_byte_r[3:0] == wsdf_pkg::OP_BINARY)) begin
            fragop_nxt = in_byte_r[3:0];
          end
          phase_nxt = wsdf_pkg::PH_HDR1;
        end
      endcase
    end
  end

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_tvalid && in_tready) in_vld_nxt = 1'b1;
    else if (proc)              in_vld_nxt = 1'b0;
    out_vld_nxt = proc ? emit : (out_vld_r && !out_tready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      phase_r   <= wsdf_pkg::PH_HDR0;
      fin_r     <= 1'b0;
      fop_r     <= 4'd0;
      mask_r    <= 1'b0;
      hbc_r     <= 4'd0;
      rem_r     <= 64'd0;
      key_r     <= 32'd0;
      mpos_r    <= 2'd0;
      fragop_r  <= 4'd0;
      ext8_r    <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
      phase_r   <= phase_nxt;
      fin_r     <= fin_nxt;
      fop_r     <= fop_nxt;
      mask_r    <= mask_nxt;
      hbc_r     <= hbc_nxt;
      rem_r     <= rem_nxt;
      key_r     <= key_nxt;
      mpos_r    <= mpos_nxt;
      fragop_r  <= fragop_nxt;
      ext8_r    <= ext8_nxt;
    end
  end

  // Payload registers: load on an accepted input transfer or a producing step
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) in_byte_r <= in_tdata;
    if (proc && emit) begin
      out_kind_r <= emit_kind;
      out_byte_r <= emit_byte;
      out_op_r   <= emit_op;
      out_last_r <= emit_last;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {4'd0, out_op_r, out_byte_r};
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

endmodule

/* sv/websocket_frame_deframer_chk.sv */
// Port-level checker for the WebSocket frame deframer, bound to the top level.
module websocket_frame_deframer_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic [2:0]  out_tuser,
  input logic        out_tlast
);

  // Stalled result transfer holds its contents
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser)
      && $stable(out_tlast))
    else $error("stalled result changed");

  // Only payload transfers carry a data byte
  a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != wsdf_pkg::EV_PAYLOAD |-> out_tdata[7:0] == 8'd0)
    else $error("non-payload event with a data byte");

  // Control-frame events never end a message
  a_ctrl_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == wsdf_pkg::EV_PING || out_tuser == wsdf_pkg::EV_PONG ||
                   out_tuser == wsdf_pkg::EV_UNKNOWN) |-> !out_tlast)
    else $error("control event marked last");

  // Ping event carries the ping opcode, and a message-end event is always last
  a_ping_op: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == wsdf_pkg::EV_PING |-> out_tdata[11:8] == wsdf_pkg::OP_PING)
    else $error("ping event with wrong opcode");

  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == wsdf_pkg::EV_MSG_END |-> out_tlast)
    else $error("message end without last");

endmodule

bind websocket_frame_deframer websocket_frame_deframer_chk u_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
